// File: rtl/grid_flag_line_raster_assert.svh
// Assertion macros shared by the grid flag line raster RTL.
`ifndef GRID_FLAG_LINE_RASTER_ASSERT_SVH
`define GRID_FLAG_LINE_RASTER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define GFLR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GFLR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/gflr_pkg.sv
// Shared types, codes and the cell update function of the grid flag line raster.
package gflr_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int MAX_THICKNESS  = 15;
   localparam int PW             = 20;  // signed coordinate width inside the sequencer
   localparam int REQ_W          = 112;
   localparam int RSP_W          = 40;
   localparam int CSR_AW         = 2;
   localparam int CSR_DW         = 16;

   localparam logic [2:0] CMD_CELL    = 3'd0;
   localparam logic [2:0] CMD_READ    = 3'd1;
   localparam logic [2:0] CMD_ALL     = 3'd2;
   localparam logic [2:0] CMD_EDGES   = 3'd3;
   localparam logic [2:0] CMD_SEGMENT = 3'd4;
   localparam logic [2:0] CMD_LINE    = 3'd5;

   localparam logic [2:0] OP_OR     = 3'd0;
   localparam logic [2:0] OP_AND    = 3'd1;
   localparam logic [2:0] OP_XOR    = 3'd2;
   localparam logic [2:0] OP_WRITE  = 3'd3;
   localparam logic [2:0] OP_WRZERO = 3'd4;
   localparam logic [2:0] OP_ANDN   = 3'd5;

   localparam logic [CSR_AW-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_WINDOW_X    = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_WINDOW_Y    = 2'd3;

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_RD, ST_WR, ST_DONE} st_type;
   typedef enum logic [1:0] {PH_MAIN, PH_SIDE, PH_START, PH_END} ph_type;

   function automatic logic [31:0] apply_op(input logic [2:0] op, input logic [31:0] cur,
                                            input logic [31:0] val);
      logic [31:0] r;
      r = cur;
      case (op)
         OP_OR:     r = cur | val;
         OP_AND:    r = cur & val;
         OP_XOR:    r = cur ^ val;
         OP_WRITE:  r = val;
         OP_WRZERO: r = (cur == 32'd0) ? val : cur;
         OP_ANDN:   r = cur & ~val;
         default:   r = cur;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/grid_flag_line_raster.sv
// Grid flag line raster: top level with command sequencer and cell RMW datapath.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | req_tdata: cmd, op, x/y start, x/y end, operand, incl, thick
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata: read_value, done_res
//  csr     | in  | csr_we             | csr_addr selects register, csr_wdata
//
// Every visited cell passes through ST_RD (RAM read), then ST_WR (write back); one command at a time.
// Segments and lines walk every point, in or out of the grid, through the same RMW slot.
// After reset a clearing pass writes zero to all MAX_WIDTH * MAX_HEIGHT words, one per
// cycle, before req_tready rises. A held response stalls the next command.
`include "grid_flag_line_raster_assert.svh"
module grid_flag_line_raster #(
   parameter int MAX_WIDTH  = gflr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gflr_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // cmd[2:0] op[5:3] x_start[21:6] y_start[37:22] x_end[53:38] y_end[69:54]
   // operand_value[101:70] include_end[102] thickness[106:103], zero fill above
   input  logic [gflr_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // read_value[31:0] done_res[32], zero fill above
   output logic [gflr_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_we,
   input  logic [gflr_pkg::CSR_AW-1:0] csr_addr,
   input  logic [gflr_pkg::CSR_DW-1:0] csr_wdata
);
   import gflr_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WCAP  = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
   localparam int HCAP  = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
   localparam int TCAP  = (MAX_THICKNESS > 15) ? 15 : MAX_THICKNESS;

   // configuration
   logic [6:0]  cfg_w_ff, cfg_h_ff;
   logic [15:0] cfg_wx_ff, cfg_wy_ff;
   logic [6:0]  w_eff, h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff  <= 7'd64;
         cfg_h_ff  <= 7'd64;
         cfg_wx_ff <= '0;
         cfg_wy_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GRID_WIDTH:  cfg_w_ff  <= csr_wdata[6:0];
            CSR_GRID_HEIGHT: cfg_h_ff  <= csr_wdata[6:0];
            CSR_WINDOW_X:    cfg_wx_ff <= csr_wdata;
            CSR_WINDOW_Y:    cfg_wy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = (cfg_w_ff == 7'd0) ? 7'd1 : cfg_w_ff;
      if (w_eff > 7'(WCAP)) w_eff = 7'(WCAP);
      h_eff = (cfg_h_ff == 7'd0) ? 7'd1 : cfg_h_ff;
      if (h_eff > 7'(HCAP)) h_eff = 7'(HCAP);
   end

   // sequencer state
   st_type             st_ff, st_in;
   ph_type             ph_ff, ph_in;
   logic               sub_ff, sub_in;
   logic [2:0]         cmd_ff, cmd_in, op_ff, op_in;
   logic [31:0]        val_ff, val_in, rd_ff, rd_in;
   logic               incl_ff, incl_in;
   logic [3:0]         n_ff, n_in, i_ff, i_in;
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [PW-1:0] xs_ff, xs_in, ys_ff, ys_in, xe_ff, xe_in, ye_ff, ye_in;
   logic signed [PW-1:0] lx_ff, lx_in, ly_ff, ly_in, lim_ff, lim_in;
   logic               vert_ff, vert_in, down_ff, down_in, sxn_ff, sxn_in, syn_ff, syn_in;
   logic [16:0]        steps_ff, steps_in, dmaj_ff, dmaj_in, dmin_ff, dmin_in;
   logic [18:0]        err_ff, err_in;
   logic               pv_ff, pv_in;
   logic [AW-1:0]      addr_ff, addr_in, clr_ff, clr_in;

   // request fields
   logic signed [PW-1:0] q_xs, q_ys, q_xe, q_ye, q_dx, q_dy, q_lo, q_hi;
   logic [16:0]        q_adx, q_ady;
   logic [3:0]         q_n;
   logic               q_eq, q_vert;

   // point and RAM
   logic signed [PW-1:0] wx, wy, pt_x, pt_y;
   logic [AW+6:0]      prod;
   logic [AW-1:0]      pt_addr;
   logic               pt_in;
   logic [18:0]        err2;
   logic signed [PW-1:0] lx_step, ly_step;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [31:0]        ram_wdata, ram_rdata;

   always_comb begin
      q_xs   = PW'($signed(req_tdata[21:6]));
      q_ys   = PW'($signed(req_tdata[37:22]));
      q_xe   = PW'($signed(req_tdata[53:38]));
      q_ye   = PW'($signed(req_tdata[69:54]));
      q_dx   = q_xe - q_xs;
      q_dy   = q_ye - q_ys;
      q_adx  = q_dx[PW-1] ? 17'(-q_dx) : 17'(q_dx);
      q_ady  = q_dy[PW-1] ? 17'(-q_dy) : 17'(q_dy);
      q_n    = (req_tdata[106:103] > 4'(TCAP)) ? 4'(TCAP) : req_tdata[106:103];
      q_eq   = (q_xs == q_xe) && (q_ys == q_ye);
      q_vert = (q_xs == q_xe);
      if (q_vert) begin
         q_lo = (q_ys >= q_ye) ? q_ye + PW'(1) : q_ys + PW'(1);
         q_hi = (q_ys >= q_ye) ? q_ys : q_ye;
      end else begin
         q_lo = (q_xs >= q_xe) ? q_xe + PW'(1) : q_xs + PW'(1);
         q_hi = (q_xs >= q_xe) ? q_xs : q_xe;
      end
   end

   // current point in grid coordinates; lines are offset by the window
   always_comb begin
      wx = PW'($signed(cfg_wx_ff));
      wy = PW'($signed(cfg_wy_ff));
      if (cmd_ff == CMD_LINE) begin
         pt_x = lx_ff - wx + (down_ff ? PW'(0) : $signed({{(PW-4){1'b0}}, i_ff}));
         pt_y = ly_ff - wy + (down_ff ? $signed({{(PW-4){1'b0}}, i_ff}) : PW'(0));
      end else begin
         pt_x = px_ff;
         pt_y = py_ff;
      end
      pt_in = !pt_x[PW-1] && !pt_y[PW-1]
            && (pt_x < $signed({{(PW-7){1'b0}}, w_eff}))
            && (pt_y < $signed({{(PW-7){1'b0}}, h_eff}));
      prod    = {7'd0, pt_y[AW-1:0]} * {{AW{1'b0}}, w_eff};
      pt_addr = prod[AW-1:0] + pt_x[AW-1:0];
      err2    = err_ff + {2'd0, dmin_ff};
      lx_step = sxn_ff ? lx_ff - PW'(1) : lx_ff + PW'(1);
      ly_step = syn_ff ? ly_ff - PW'(1) : ly_ff + PW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff <= ph_in;     sub_ff <= sub_in;   cmd_ff <= cmd_in;   op_ff <= op_in;
      val_ff <= val_in;   rd_ff <= rd_in;     incl_ff <= incl_in; n_ff <= n_in;
      i_ff <= i_in;       px_ff <= px_in;     py_ff <= py_in;     xs_ff <= xs_in;
      ys_ff <= ys_in;     xe_ff <= xe_in;     ye_ff <= ye_in;     lx_ff <= lx_in;
      ly_ff <= ly_in;     lim_ff <= lim_in;   vert_ff <= vert_in; down_ff <= down_in;
      sxn_ff <= sxn_in;   syn_ff <= syn_in;   steps_ff <= steps_in;
      dmaj_ff <= dmaj_in; dmin_ff <= dmin_in; err_ff <= err_in;   pv_ff <= pv_in;
      addr_ff <= addr_in;
   end

   always_comb begin
      st_in = st_ff;     ph_in = ph_ff;     sub_in = sub_ff;   cmd_in = cmd_ff;
      op_in = op_ff;     val_in = val_ff;   rd_in = rd_ff;     incl_in = incl_ff;
      n_in = n_ff;       i_in = i_ff;       px_in = px_ff;     py_in = py_ff;
      xs_in = xs_ff;     ys_in = ys_ff;     xe_in = xe_ff;     ye_in = ye_ff;
      lx_in = lx_ff;     ly_in = ly_ff;     lim_in = lim_ff;   vert_in = vert_ff;
      down_in = down_ff; sxn_in = sxn_ff;   syn_in = syn_ff;   steps_in = steps_ff;
      dmaj_in = dmaj_ff; dmin_in = dmin_ff; err_in = err_ff;   pv_in = pv_ff;
      addr_in = addr_ff; clr_in = clr_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = addr_ff;
      ram_wdata  = apply_op(op_ff, ram_rdata, val_ff);

      unique case (st_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in  = req_tdata[2:0];
               op_in   = req_tdata[5:3];
               val_in  = req_tdata[101:70];
               incl_in = 1'b0;
               n_in    = q_n;
               rd_in   = '0;
               xs_in = q_xs; ys_in = q_ys; xe_in = q_xe; ye_in = q_ye;
               px_in = q_xs; py_in = q_ys;
               ph_in = PH_START;
               sub_in = 1'b0;
               st_in = ST_RD;
               case (req_tdata[2:0]) inside
                  CMD_CELL, CMD_READ: ;
                  CMD_ALL, CMD_EDGES: begin
                     px_in = '0; py_in = '0; ph_in = PH_MAIN;
                  end
                  CMD_SEGMENT: begin
                     vert_in = q_vert;
                     lim_in  = q_hi;
                     if (!q_eq) begin
                        incl_in = req_tdata[102];
                        if (q_hi > q_lo) begin
                           ph_in = PH_MAIN;
                           if (q_vert) py_in = q_lo;
                           else px_in = q_lo;
                        end
                     end
                  end
                  CMD_LINE: begin
                     lx_in = q_xs; ly_in = q_ys;
                     sxn_in = q_dx[PW-1]; syn_in = q_dy[PW-1];
                     down_in = (q_adx >= q_ady);
                     dmaj_in = (q_adx >= q_ady) ? q_adx : q_ady;
                     dmin_in = (q_adx >= q_ady) ? q_ady : q_adx;
                     steps_in = (q_adx >= q_ady) ? q_adx : q_ady;
                     err_in = '0;
                     i_in = '0;
                     if (q_n == 4'd0) st_in = ST_DONE;
                  end
                  default: st_in = ST_DONE;
               endcase
            end
         end
         ST_RD: begin
            pv_in   = pt_in;
            addr_in = pt_addr;
            st_in   = ST_WR;
         end
         ST_WR: begin
            // a read only samples the cell, never writes it back
            ram_we = pv_ff && (cmd_ff != CMD_READ);
            st_in  = ST_RD;
            if (cmd_ff == CMD_READ) rd_in = pv_ff ? ram_rdata : 32'd0;
            case (cmd_ff)
               CMD_ALL: begin
                  if (px_ff == PW'(w_eff) - PW'(1)) begin
                     px_in = '0;
                     py_in = py_ff + PW'(1);
                     if (py_ff == PW'(h_eff) - PW'(1)) st_in = ST_DONE;
                  end else begin
                     px_in = px_ff + PW'(1);
                  end
               end
               CMD_EDGES: begin
                  if (ph_ff == PH_MAIN) begin
                     if (!sub_ff) begin
                        sub_in = 1'b1;
                        py_in  = PW'(h_eff) - PW'(1);
                     end else begin
                        sub_in = 1'b0;
                        if (px_ff == PW'(w_eff) - PW'(1)) begin
                           ph_in = PH_SIDE;
                           px_in = '0;
                           py_in = PW'(1);
                           if (h_eff == 7'd1) st_in = ST_DONE;
                        end else begin
                           px_in = px_ff + PW'(1);
                           py_in = '0;
                        end
                     end
                  end else begin
                     if (!sub_ff) begin
                        sub_in = 1'b1;
                        px_in  = PW'(w_eff) - PW'(1);
                     end else begin
                        sub_in = 1'b0;
                        px_in  = '0;
                        py_in  = py_ff + PW'(1);
                        if (py_ff == PW'(h_eff) - PW'(1)) st_in = ST_DONE;
                     end
                  end
               end
               CMD_LINE: begin
                  if (i_ff != n_ff - 4'd1) begin
                     i_in = i_ff + 4'd1;
                  end else begin
                     i_in = '0;
                     if (steps_ff == 17'd0) begin
                        st_in = ST_DONE;
                     end else begin
                        steps_in = steps_ff - 17'd1;
                        // strict test: minor axis moves only when err exceeds major length
                        if (err2 > {2'd0, dmaj_ff}) begin
                           err_in = err2 - {2'd0, dmaj_ff};
                           lx_in  = lx_step;
                           ly_in  = ly_step;
                        end else begin
                           err_in = err2;
                           if (down_ff) lx_in = lx_step;
                           else ly_in = ly_step;
                        end
                     end
                  end
               end
               default: begin
                  // cell, read and segment share the start and end tail
                  case (ph_ff)
                     PH_MAIN: begin
                        if (vert_ff) begin
                           py_in = py_ff + PW'(1);
                           if (py_ff + PW'(1) == lim_ff) begin
                              ph_in = PH_START; px_in = xs_ff; py_in = ys_ff;
                           end
                        end else begin
                           px_in = px_ff + PW'(1);
                           if (px_ff + PW'(1) == lim_ff) begin
                              ph_in = PH_START; px_in = xs_ff; py_in = ys_ff;
                           end
                        end
                     end
                     PH_START: begin
                        if (incl_ff) begin
                           ph_in = PH_END; px_in = xe_ff; py_in = ye_ff;
                        end else begin
                           st_in = ST_DONE;
                        end
                     end
                     default: st_in = ST_DONE;
                  endcase
               end
            endcase
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = {7'd0, 1'b1, rd_ff};

   gflr_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_in),
      .rdata (ram_rdata)
   );

   `GFLR_ASSERT_IMP(a_ready_rsp_excl, req_tready, !rsp_tvalid, "ready while response held")
   `GFLR_ASSERT_NXT(a_busy_after_acc, req_tvalid && req_tready, !req_tready,
                    "ready right after transaction")
   `GFLR_ASSERT_IMP(a_no_write_idle, st_ff == ST_IDLE || st_ff == ST_DONE, !ram_we,
                    "cell write outside a command")
   `GFLR_ASSERT_IMP(a_wr_in_range, ram_we, ram_waddr <= AW'(DEPTH - 1), "cell address range")
endmodule

// File: rtl/gflr_ram.sv
// Generic single write, single read RAM with registered read data.
module gflr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
